/* rtl/byte_stream_lookup2_hash_core_assert.svh */
// Assertion macros shared by the hash core modules.
`ifndef BYTE_STREAM_LOOKUP2_HASH_CORE_ASSERT_SVH
`define BYTE_STREAM_LOOKUP2_HASH_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSLH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bslh assertion failed");
`define BSLH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bslh assertion failed");
`define BSLH_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) 1'b1 |-> !(cond)) \
        else $error("bslh assertion failed");
`else
`define BSLH_ASSERT_IMP(lbl, ante, cons)
`define BSLH_ASSERT_NXT(lbl, ante, cons)
`define BSLH_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/bslh_pkg.sv */
// Types, constants and the mix step function of the lookup2 hash core.
package bslh_pkg;

    localparam int BLOCK_BYTES = 12;
    localparam int BLOCK_W     = 8 * BLOCK_BYTES;
    localparam int CNT_W       = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;
    localparam int NSTEPS      = 9;

    localparam logic [3:0]  POS_LAST = 4'd11;
    localparam logic [31:0] GOLDEN   = 32'h9e3779b9;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] hash;
        logic [23:0] short_id;
    } t_out;

    // one request to the mixer: a full block, a final block, or both in turn
    typedef struct packed {
        logic               first;
        logic               full;
        logic               fin;
        logic [BLOCK_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
    } t_cmd;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_mix;

    function automatic t_mix mix_step(input logic [3:0] idx, input t_mix m);
        t_mix r;
        r = m;
        case (idx)
            4'd0: begin
                r.a = m.a - (m.b + m.c);
                r.a = r.a ^ (m.c >> 13);
            end
            4'd1: begin
                r.b = m.b - (m.a + m.c);
                r.b = r.b ^ (m.a << 8);
            end
            4'd2: begin
                r.c = m.c - (m.a + m.b);
                r.c = r.c ^ (m.b >> 13);
            end
            4'd3: begin
                r.a = m.a - (m.b + m.c);
                r.a = r.a ^ (m.c >> 12);
            end
            4'd4: begin
                r.b = m.b - (m.a + m.c);
                r.b = r.b ^ (m.a << 16);
            end
            4'd5: begin
                r.c = m.c - (m.a + m.b);
                r.c = r.c ^ (m.b >> 5);
            end
            4'd6: begin
                r.a = m.a - (m.b + m.c);
                r.a = r.a ^ (m.c >> 3);
            end
            4'd7: begin
                r.b = m.b - (m.a + m.c);
                r.b = r.b ^ (m.a << 10);
            end
            4'd8: begin
                r.c = m.c - (m.a + m.b);
                r.c = r.c ^ (m.b >> 15);
            end
            default: begin
                r = m;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/bslh_front.sv */
// Front end: gathers bytes into 12-byte blocks and issues mixer requests.
`include "byte_stream_lookup2_hash_core_assert.svh"
module bslh_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  bslh_pkg::t_in    i_in,
    output logic             o_push,
    output bslh_pkg::t_cmd   o_cmd
);

    logic [bslh_pkg::BLOCK_W-1:0] r_blk, n_blk;
    logic [3:0]                   r_pos, n_pos;
    logic [COUNT_BITS-1:0]        r_cnt, n_cnt;
    logic                         r_sent, n_sent;

    logic [bslh_pkg::BLOCK_W-1:0] blk_new;
    logic [COUNT_BITS-1:0]        cnt_new;
    logic                         pos_full;

    always_comb begin
        blk_new = r_blk;
        for (int i = 0; i < bslh_pkg::BLOCK_BYTES; i++) begin
            if (i_in.has_byte && r_pos == 4'(i)) begin
                blk_new[i*8 +: 8] = i_in.data;
            end
        end
        cnt_new  = r_cnt + COUNT_BITS'(i_in.has_byte);
        pos_full = i_in.has_byte && (r_pos == bslh_pkg::POS_LAST);
    end

    always_comb begin
        o_push      = pos_full || i_in.last;
        o_cmd.first = !r_sent;
        o_cmd.full  = pos_full;
        o_cmd.fin   = i_in.last;
        o_cmd.bytes = blk_new;
        o_cmd.count = bslh_pkg::CNT_W'(cnt_new);
    end

    always_comb begin
        n_blk  = r_blk;
        n_pos  = r_pos;
        n_cnt  = r_cnt;
        n_sent = r_sent;
        if (i_acc) begin
            if (i_in.last) begin
                n_blk  = '0;
                n_pos  = '0;
                n_cnt  = '0;
                n_sent = 1'b0;
            end else if (pos_full) begin
                n_blk  = '0;
                n_pos  = '0;
                n_cnt  = cnt_new;
                n_sent = 1'b1;
            end else if (i_in.has_byte) begin
                n_blk  = blk_new;
                n_pos  = r_pos + 4'd1;
                n_cnt  = cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk  <= '0;
            r_pos  <= '0;
            r_cnt  <= '0;
            r_sent <= 1'b0;
        end else begin
            r_blk  <= n_blk;
            r_pos  <= n_pos;
            r_cnt  <= n_cnt;
            r_sent <= n_sent;
        end
    end

    // before the first block goes out the count is just the fill level
    `BSLH_ASSERT_IMP(a_cnt_matches_pos, !r_sent, r_cnt == COUNT_BITS'(r_pos))
    `BSLH_ASSERT_NXT(a_last_clears, i_acc && i_in.last, r_pos == 4'd0 && !r_sent)
    `BSLH_ASSERT_NEVER(a_pos_range, r_pos > bslh_pkg::POS_LAST)

endmodule

/* rtl/bslh_queue.sv */
// Short request queue between the front end and the mixer.
`include "byte_stream_lookup2_hash_core_assert.svh"
module bslh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bslh_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bslh_pkg::t_cmd o_cmd
);

    bslh_pkg::t_cmd                  r_mem [bslh_pkg::QDEPTH];
    logic [bslh_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [bslh_pkg::QCNT_W-1:0]     r_cnt;

    assign o_full  = (r_cnt == bslh_pkg::QCNT_W'(bslh_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + bslh_pkg::QCNT_W'(i_push) - bslh_pkg::QCNT_W'(i_pop);
        end
    end

    `BSLH_ASSERT_NEVER(a_no_overflow, i_push && o_full && !i_pop)
    `BSLH_ASSERT_NEVER(a_no_underflow, i_pop && !o_valid)
    `BSLH_ASSERT_NXT(a_drain, i_pop && !i_push, r_cnt == $past(r_cnt) - 1'b1)

endmodule

/* rtl/bslh_mixer.sv */
// Back end: ten-stage add-and-mix pipeline with a single chain register.
`include "byte_stream_lookup2_hash_core_assert.svh"
module bslh_mixer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bslh_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bslh_pkg::t_out o_out
);

    localparam int LAST_ST = bslh_pkg::NSTEPS;

    bslh_pkg::t_mix   r_st [LAST_ST+1];
    logic [LAST_ST:0] r_vld;
    logic [LAST_ST:0] r_fin;
    bslh_pkg::t_mix   r_chain;
    logic             r_ch_valid;
    logic             r_half;
    logic             r_out_valid;
    bslh_pkg::t_out   r_out;

    logic           en;
    logic           part_full;
    logic           use_gold;
    logic           can_enter;
    logic           exit_nf;
    bslh_pkg::t_mix base;
    bslh_pkg::t_mix word;
    bslh_pkg::t_mix ent;

    assign en = !r_out_valid || !i_out_stall;

    always_comb begin
        // a full block that also ends the message runs twice: block, then final
        part_full = i_cmd.full && !r_half;
        use_gold  = i_cmd.first && (part_full || !i_cmd.full);
        can_enter = i_valid && en && (use_gold || r_ch_valid);
        o_pop     = can_enter && (!part_full || !i_cmd.fin);
        exit_nf   = en && r_vld[LAST_ST] && !r_fin[LAST_ST];

        if (use_gold) begin
            base.a = bslh_pkg::GOLDEN;
            base.b = bslh_pkg::GOLDEN;
            base.c = '0;
        end else begin
            base = r_chain;
        end

        if (part_full) begin
            word.a = i_cmd.bytes[31:0];
            word.b = i_cmd.bytes[63:32];
            word.c = i_cmd.bytes[95:64];
        end else if (i_cmd.full) begin
            word.a = '0;
            word.b = '0;
            word.c = i_cmd.count;
        end else begin
            word.a = i_cmd.bytes[31:0];
            word.b = i_cmd.bytes[63:32];
            word.c = {i_cmd.bytes[87:64], 8'h00} + i_cmd.count;
        end

        ent.a = base.a + word.a;
        ent.b = base.b + word.b;
        ent.c = base.c + word.c;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0] <= ent;
            r_fin   <= {r_fin[LAST_ST-1:0], !part_full};
            for (int k = 1; k <= LAST_ST; k++) begin
                r_st[k] <= bslh_pkg::mix_step(4'(k - 1), r_st[k-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exit_nf) begin
            r_chain <= r_st[LAST_ST];
        end
        if (en) begin
            r_out.hash     <= r_st[LAST_ST].c;
            r_out.short_id <= r_st[LAST_ST].c[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_ch_valid  <= 1'b0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_vld       <= {r_vld[LAST_ST-1:0], can_enter};
                r_out_valid <= r_vld[LAST_ST] && r_fin[LAST_ST];
            end
            if (exit_nf) begin
                r_ch_valid <= 1'b1;
            end else if (can_enter && !use_gold) begin
                r_ch_valid <= 1'b0;
            end
            if (can_enter && part_full && i_cmd.fin) begin
                r_half <= 1'b1;
            end else if (o_pop) begin
                r_half <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // only one unfinished message can have a block in flight or parked
    `BSLH_ASSERT_NEVER(a_one_chain, ($countones(r_vld & ~r_fin) + 32'(r_ch_valid)) > 1)
    `BSLH_ASSERT_IMP(a_half_head, r_half, i_valid && i_cmd.full && i_cmd.fin)
    `BSLH_ASSERT_NEVER(a_chain_overwrite, exit_nf && r_ch_valid)

endmodule

/* rtl/byte_stream_lookup2_hash_core.sv */
// Lookup2 (jhash, initial value zero) over a byte stream: top level.
//
// Input channel i_in_valid / o_in_stall carries one byte per request (data,
// has_byte, last). A request with last = 1 closes the message; has_byte = 0
// with last = 1 closes it without adding a byte. Output channel o_out_valid /
// i_out_stall carries one request per message: the 32-bit hash and its low
// 24 bits. A request moves on a rising edge with valid high and stall low.
// Throughput: one input request per cycle while o_in_stall is low. The front
// end packs bytes into 12-byte blocks and queues mixer requests; the mixer
// is a ten-stage pipeline (load add, then one mix step per stage), so
// independent messages overlap. The last byte passes the queue, the pipeline
// and the output register on its way to o_out_valid; when the message
// carries any full block, its final block waits for the previous block to
// leave the pipeline. The queue (4 deep) stalls the input only when full.
// Reset (i_rst_n low, synchronous) empties the queue and pipeline and drops
// any partial message. While a result waits on i_out_stall it holds and the
// pipeline freezes; the input keeps flowing until the queue is full.
module byte_stream_lookup2_hash_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bslh_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bslh_pkg::t_out o_out
);

    logic           acc;
    logic           f_push;
    bslh_pkg::t_cmd f_cmd;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    bslh_pkg::t_cmd q_cmd;

    assign o_in_stall = q_full;
    assign acc        = i_in_valid && !q_full;

    bslh_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_in    (i_in),
        .o_push  (f_push),
        .o_cmd   (f_cmd)
    );

    bslh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc && f_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    bslh_mixer u_mixer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the byte stream lookup2 hash core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    bslh_pkg::t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    bslh_pkg::t_out o_out;

    byte_stream_lookup2_hash_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // running hash of the open message
    logic [31:0] acc_a = bslh_pkg::GOLDEN;
    logic [31:0] acc_b = bslh_pkg::GOLDEN;
    logic [31:0] acc_c = '0;
    logic [7:0]  blk_bytes [12];
    int unsigned blk_fill = 0;
    logic [31:0] msg_len = '0;

    bslh_pkg::t_out hash_due [$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned sink_hold = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned pick_gap(input bit burst);
        if (burst || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [31:0] blk_word(input int unsigned at);
        return {blk_bytes[at+3], blk_bytes[at+2], blk_bytes[at+1], blk_bytes[at]};
    endfunction

    task automatic jumble(inout logic [31:0] a, inout logic [31:0] b,
                          inout logic [31:0] c);
        a = (a - b - c) ^ (c >> 13);
        b = (b - a - c) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - a - c) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - a - c) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
    endtask

    task automatic clear_block();
        foreach (blk_bytes[i])
            blk_bytes[i] = 8'h00;
        blk_fill = 0;
    endtask

    task automatic predict_hash(input bslh_pkg::t_in req);
        bslh_pkg::t_out r;
        if (req.has_byte) begin
            blk_bytes[blk_fill] = req.data;
            blk_fill++;
            msg_len++;
            if (blk_fill == bslh_pkg::BLOCK_BYTES) begin
                acc_a += blk_word(0);
                acc_b += blk_word(4);
                acc_c += blk_word(8);
                jumble(acc_a, acc_b, acc_c);
                clear_block();
            end
        end
        if (req.last) begin
            // tail bytes sit one byte up in c, and the length is added to c
            acc_a += blk_word(0);
            acc_b += blk_word(4);
            acc_c += {blk_bytes[10], blk_bytes[9], blk_bytes[8], 8'h00};
            acc_c += msg_len;
            jumble(acc_a, acc_b, acc_c);
            r.hash = acc_c;
            r.short_id = acc_c[23:0];
            hash_due.push_back(r);
            acc_a = bslh_pkg::GOLDEN;
            acc_b = bslh_pkg::GOLDEN;
            acc_c = '0;
            msg_len = '0;
            clear_block();
        end
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] hash check failed: %s got %h want %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        bslh_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (hash_due.size() == 0) begin
                note_mismatch("result with none due, hash", o_out.hash, '0);
            end else begin
                want = hash_due.pop_front();
                if (o_out.hash !== want.hash)
                    note_mismatch("hash", o_out.hash, want.hash);
                if (o_out.short_id !== want.short_id)
                    note_mismatch("short_id", {8'h00, o_out.short_id}, {8'h00, want.short_id});
            end
        end
    end

    // result side: random stalls, plus a long hold-off when one is asked for
    initial begin : result_sink
        int unsigned wait_n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (sink_hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (sink_hold) @(posedge i_clk);
                sink_hold = 0;
            end
            wait_n = pick_gap(rx_burst);
            if (wait_n != 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic [7:0] d, input bit hb, input bit lst);
        bslh_pkg::t_in req;
        int unsigned wait_n;
        req.data = d;
        req.has_byte = hb;
        req.last = lst;
        wait_n = pick_gap(tx_burst);
        if (wait_n != 0) begin
            i_in_valid <= 1'b0;
            repeat (wait_n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (o_in_stall);
        predict_hash(req);
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (hash_due.size() != 0);
    endtask

    // stray empty requests ride along as noise; some messages close with an empty last
    task automatic send_message(input int unsigned nbytes, input bit sep_end);
        for (int unsigned i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, !sep_end && i == nbytes - 1);
        end
        if (sep_end || nbytes == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 9))
            0, 1:    return 12 * $urandom_range(0, 3);
            2:       return 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
            9:       return ($urandom_range(0, 3) == 0) ? $urandom_range(31, 150)
                                                       : $urandom_range(1, 11);
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);          // empty message
        send_item(8'h5a, 1'b0, 1'b0);          // empty request, ignored
        send_item(8'hff, 1'b1, 1'b1);
        // twelfth byte arrives with last: full block then all-zero tail
        for (int unsigned i = 0; i < 12; i++)
            send_item((i == 0) ? 8'hff : (i == 11) ? 8'h00 : 8'(i * 37), 1'b1, i == 11);
        for (int unsigned i = 0; i < 9; i++)
            send_item(8'(8'h80 + i), 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_messages(input int unsigned goal);
        int unsigned stop_at;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 29) == 0)
                tx_burst = ~tx_burst;
            if ($urandom_range(0, 29) == 0)
                rx_burst = ~rx_burst;
            send_message(pick_len(), $urandom_range(0, 3) == 0);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic test_back_to_back(input int unsigned goal);
        int unsigned stop_at;
        stop_at = items_sent + goal;
        tx_burst = 1'b1;
        rx_burst = 1'b1;
        while (items_sent < stop_at)
            send_message(pick_len(), $urandom_range(0, 3) == 0);
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // short messages at full rate against a held output fill the queue
    task automatic test_output_hold();
        sink_hold = HOLD_CYCLES;
        tx_burst = 1'b1;
        repeat (40)
            send_message($urandom_range(0, 3), $urandom_range(0, 3) == 0);
        tx_burst = 1'b0;
        wait_drain();
    endtask

    task automatic test_drain_pause();
        repeat (6) begin
            repeat ($urandom_range(1, 4))
                send_message(pick_len(), $urandom_range(0, 3) == 0);
            wait_drain();
        end
    endtask

    initial begin
        foreach (blk_bytes[i])
            blk_bytes[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_messages(600);
        test_back_to_back(250);
        test_output_hold();
        test_drain_pause();
        test_random_messages(200);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && hash_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/bslh_pkg.sv
rtl/bslh_front.sv
rtl/bslh_queue.sv
rtl/bslh_mixer.sv
rtl/byte_stream_lookup2_hash_core.sv
sim/testbench.sv
